// ===== design/ujf_pkg.sv =====
package ujf_pkg;

  localparam int FRAME_BYTES = 128;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int LEN_W       = ADDR_W;
  localparam int POS_W       = ADDR_W + 1;
  localparam int FREQ_W      = 31;

  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(FRAME_BYTES - 1);
  localparam logic [FREQ_W-1:0] SAT_MAX   = {FREQ_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_RST  = FREQ_W'(100);
  localparam logic [FREQ_W-1:0] MAX_RST   = FREQ_W'(10000000);
  localparam logic [POS_W-1:0]  DIR_SKIP  = POS_W'(12);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] W_FREQ      = 3'd0;
  localparam logic [2:0] W_FREQUENCY = 3'd1;
  localparam logic [2:0] W_DIRECTION = 3'd2;
  localparam logic [2:0] W_FORWARD   = 3'd3;
  localparam logic [2:0] W_BACKWARD  = 3'd4;

  localparam logic [6*8-1:0]  S_FREQ      = "\"freq\"";
  localparam logic [11*8-1:0] S_FREQUENCY = "\"frequency\"";
  localparam logic [11*8-1:0] S_DIRECTION = "\"direction\"";
  localparam logic [9*8-1:0]  S_FORWARD   = "\"forward\"";
  localparam logic [10*8-1:0] S_BACKWARD  = "\"backward\"";

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] frequency_hz;
    logic              freq_applied;
    logic              direction;
    logic              dir_applied;
  } ujf_result_t;

  function automatic logic [3:0] word_len(input logic [2:0] w);
    logic [3:0] n;
    case (w)
      W_FREQ:      n = 4'd6;
      W_FREQUENCY: n = 4'd11;
      W_DIRECTION: n = 4'd11;
      W_FORWARD:   n = 4'd9;
      W_BACKWARD:  n = 4'd10;
      default:     n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] k);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      W_FREQ:      if (k < 4'd6)  c = S_FREQ[8*(5-k) +: 8];
      W_FREQUENCY: if (k < 4'd11) c = S_FREQUENCY[8*(10-k) +: 8];
      W_DIRECTION: if (k < 4'd11) c = S_DIRECTION[8*(10-k) +: 8];
      W_FORWARD:   if (k < 4'd9)  c = S_FORWARD[8*(8-k) +: 8];
      W_BACKWARD:  if (k < 4'd10) c = S_BACKWARD[8*(9-k) +: 8];
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/uart_json_freq_dir_command_parser.sv =====
// Byte-wide command parser. A byte is taken when start is high and busy is
// low. A closing brace queues the frame for the scanner, which reads the
// frame buffer through its single registered read port, waiting for each
// read before it acts on the byte. A search for the freq, frequency or
// direction key restarts at every position of the frame. busy is high
// during reset and while a frame is queued or being scanned; it falls in
// the cycle that out_valid pulses. The result strobe lasts one cycle and
// cannot be held off, so sample it when it comes.
module uart_json_freq_dir_command_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        cfg_we,
  input  logic [ujf_pkg::FREQ_W-1:0]  cfg_max_freq_hz,
  output logic                        out_valid,
  output logic [ujf_pkg::FREQ_W-1:0]  out_frequency_hz,
  output logic                        out_freq_applied,
  output logic                        out_direction,
  output logic                        out_dir_applied
);
  import ujf_pkg::*;

  logic              accept, push, pop, q_valid, back_busy;
  logic [LEN_W-1:0]  push_len, head_len;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  ujf_result_t       result;

  assign busy   = !rst_n || q_valid || back_busy;
  assign accept = start && !busy;

  ujf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_len (push_len),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  ujf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_len  (push_len),
    .pop       (pop),
    .not_empty (q_valid),
    .head_len  (head_len)
  );

  ujf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_max (cfg_max_freq_hz),
    .q_valid (q_valid),
    .q_len   (head_len),
    .q_pop   (pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (back_busy),
    .result  (result)
  );

  assign out_valid        = result.valid;
  assign out_frequency_hz = result.frequency_hz;
  assign out_freq_applied = result.freq_applied;
  assign out_direction    = result.direction;
  assign out_dir_applied  = result.dir_applied;

endmodule

// ===== design/ujf_front.sv =====
module ujf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 rx_byte,
  output logic                       push,
  output logic [ujf_pkg::LEN_W-1:0]  push_len,
  input  logic [ujf_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import ujf_pkg::*;

  logic [7:0]       mem [FRAME_BYTES];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       rd_data_r;
  logic             wr_en;
  logic [LEN_W-1:0] wr_addr;
  logic             is_open;

  assign is_open = (len_r != '0);

  always_comb begin
    len_nxt  = len_r;
    wr_en    = 1'b0;
    wr_addr  = len_r;
    push     = 1'b0;
    push_len = len_r;
    if (accept) begin
      if (rx_byte == CH_LBRACE) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        len_nxt = LEN_W'(1);
      end else begin
        if (is_open && len_r < LEN_MAX) begin
          wr_en   = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
        // close the frame and hand its length to the scanner
        if (rx_byte == CH_RBRACE && is_open) begin
          push     = 1'b1;
          push_len = len_nxt;
          len_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ujf_queue.sv =====
module ujf_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [ujf_pkg::LEN_W-1:0] push_len,
  input  logic                      pop,
  output logic                      not_empty,
  output logic [ujf_pkg::LEN_W-1:0] head_len
);
  import ujf_pkg::*;

  logic [LEN_W-1:0] slot_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign head_len  = slot_r[rp_r];
  assign do_push   = push && (cnt_r != 2'd2);
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_len;
    end
  end

endmodule

// ===== design/ujf_back.sv =====
module ujf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ujf_pkg::FREQ_W-1:0]  cfg_max,
  input  logic                        q_valid,
  input  logic [ujf_pkg::LEN_W-1:0]   q_len,
  output logic                        q_pop,
  output logic [ujf_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        busy,
  output ujf_pkg::ujf_result_t        result
);
  import ujf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_END   = 4'd1;
  localparam logic [3:0] ST_FIND  = 4'd2;
  localparam logic [3:0] ST_COLON = 4'd3;
  localparam logic [3:0] ST_SPTAB = 4'd4;
  localparam logic [3:0] ST_NWS   = 4'd5;
  localparam logic [3:0] ST_DIG   = 4'd6;
  localparam logic [3:0] ST_DSKIP = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]        st_r, st_nxt;
  logic              ph_r, ph_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, start_r, start_nxt, lim_r, lim_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [2:0]        wsel_r, wsel_nxt;
  logic              mm_r, mm_nxt, for_dir_r, for_dir_nxt;
  logic              neg_r, neg_nxt, any_r, any_nxt;
  logic [FREQ_W-1:0] val_r, val_nxt, freq_r, freq_nxt, max_r, max_nxt;
  logic              dir_r, dir_nxt, fa_r, fa_nxt, da_r, da_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        cb;
  logic [34:0]       acc;
  logic              is_ws, is_dig;

  assign rd_addr = pos_r[ADDR_W-1:0];
  assign cb      = (pos_r < lim_r) ? rd_data : 8'h00;
  assign is_ws   = (cb == CH_SPACE) || (cb >= CH_TAB && cb <= CH_CR);
  assign is_dig  = (cb >= CH_ZERO) && (cb <= CH_NINE);
  assign acc     = ({4'b0, val_r} << 3) + ({4'b0, val_r} << 1)
                 + {31'b0, 4'(cb - CH_ZERO)};
  assign busy    = (st_r != ST_IDLE);

  always_comb begin
    st_nxt      = st_r;
    ph_nxt      = ~ph_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    lim_nxt     = lim_r;
    k_nxt       = k_r;
    wsel_nxt    = wsel_r;
    mm_nxt      = mm_r;
    for_dir_nxt = for_dir_r;
    neg_nxt     = neg_r;
    any_nxt     = any_r;
    val_nxt     = val_r;
    freq_nxt    = freq_r;
    dir_nxt     = dir_r;
    fa_nxt      = fa_r;
    da_nxt      = da_r;
    valid_nxt   = 1'b0;
    max_nxt     = cfg_we ? cfg_max : max_r;
    q_pop       = 1'b0;

    case (st_r)
      ST_IDLE: begin
        ph_nxt = 1'b0;
        if (q_valid) begin
          q_pop   = 1'b1;
          lim_nxt = {1'b0, q_len};
          pos_nxt = '0;
          fa_nxt  = 1'b0;
          da_nxt  = 1'b0;
          st_nxt  = ST_END;
        end
      end
      ST_DONE: begin
        valid_nxt = 1'b1;
        st_nxt    = ST_IDLE;
      end
      default: begin
        // while ph_r is low, wait for the registered read; while it is high, act on it
        if (ph_r) begin
          case (st_r)
            ST_END: begin
              if (cb == 8'h00) begin
                lim_nxt   = pos_r;
                pos_nxt   = '0;
                start_nxt = '0;
                k_nxt     = '0;
                wsel_nxt  = W_FREQ;
                mm_nxt    = 1'b0;
                st_nxt    = ST_FIND;
              end else begin
                pos_nxt = pos_r + POS_W'(1);
              end
            end
            ST_FIND: begin
              if (cb == word_char(wsel_r, k_r)) begin
                if (k_r == word_len(wsel_r) - 4'd1) begin
                  case (wsel_r)
                    W_FREQ, W_FREQUENCY: begin
                      pos_nxt = start_r;
                      st_nxt  = ST_COLON;
                    end
                    W_DIRECTION: begin
                      pos_nxt = start_r + DIR_SKIP;
                      st_nxt  = ST_DSKIP;
                    end
                    W_FORWARD: begin
                      dir_nxt = 1'b0;
                      da_nxt  = 1'b1;
                      st_nxt  = ST_DONE;
                    end
                    default: begin
                      dir_nxt = 1'b1;
                      da_nxt  = 1'b1;
                      st_nxt  = ST_DONE;
                    end
                  endcase
                end else begin
                  k_nxt   = k_r + 4'd1;
                  pos_nxt = pos_r + POS_W'(1);
                end
              end else if (!mm_r && (start_r + POS_W'(1) < lim_r)) begin
                start_nxt = start_r + POS_W'(1);
                pos_nxt   = start_r + POS_W'(1);
                k_nxt     = '0;
              end else begin
                k_nxt = '0;
                case (wsel_r)
                  W_FREQ: begin
                    wsel_nxt  = W_FREQUENCY;
                    start_nxt = '0;
                    pos_nxt   = '0;
                  end
                  W_FORWARD: begin
                    wsel_nxt = W_BACKWARD;
                    pos_nxt  = start_r;
                  end
                  W_BACKWARD: begin
                    pos_nxt     = start_r;
                    for_dir_nxt = 1'b1;
                    neg_nxt     = 1'b0;
                    any_nxt     = 1'b0;
                    val_nxt     = '0;
                    st_nxt      = ST_NWS;
                  end
                  default: st_nxt = ST_DONE;
                endcase
              end
            end
            ST_COLON: begin
              if (pos_r >= lim_r) begin
                st_nxt = ST_DONE;
              end else begin
                pos_nxt = pos_r + POS_W'(1);
                if (cb == CH_COLON) begin
                  st_nxt = ST_SPTAB;
                end
              end
            end
            ST_SPTAB: begin
              if (cb == CH_SPACE || cb == CH_TAB) begin
                pos_nxt = pos_r + POS_W'(1);
              end else begin
                for_dir_nxt = 1'b0;
                neg_nxt     = 1'b0;
                any_nxt     = 1'b0;
                val_nxt     = '0;
                st_nxt      = ST_NWS;
              end
            end
            ST_NWS: begin
              if (is_ws) begin
                pos_nxt = pos_r + POS_W'(1);
              end else if (cb == CH_PLUS || cb == CH_MINUS) begin
                neg_nxt = (cb == CH_MINUS);
                pos_nxt = pos_r + POS_W'(1);
                st_nxt  = ST_DIG;
              end else begin
                st_nxt = ST_DIG;
              end
            end
            ST_DIG: begin
              if (is_dig) begin
                any_nxt = 1'b1;
                val_nxt = (acc > {4'b0, SAT_MAX}) ? SAT_MAX : acc[FREQ_W-1:0];
                pos_nxt = pos_r + POS_W'(1);
              end else if (for_dir_r) begin
                st_nxt = ST_DONE;
                if (any_r && (val_r == '0 || (!neg_r && val_r == FREQ_W'(1)))) begin
                  dir_nxt = val_r[0];
                  da_nxt  = 1'b1;
                end
              end else if (any_r && !neg_r && val_r != '0) begin
                if (val_r <= max_r) begin
                  freq_nxt = val_r;
                  fa_nxt   = 1'b1;
                end
                wsel_nxt  = W_DIRECTION;
                mm_nxt    = 1'b0;
                start_nxt = '0;
                pos_nxt   = '0;
                k_nxt     = '0;
                st_nxt    = ST_FIND;
              end else begin
                st_nxt = ST_DONE;
              end
            end
            ST_DSKIP: begin
              if (pos_r < lim_r && (cb == CH_SPACE || cb == CH_TAB || cb == CH_COLON)) begin
                pos_nxt = pos_r + POS_W'(1);
              end else begin
                start_nxt = pos_r;
                k_nxt     = '0;
                wsel_nxt  = W_FORWARD;
                mm_nxt    = 1'b1;
                st_nxt    = ST_FIND;
              end
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ph_r    <= 1'b0;
      freq_r  <= FREQ_RST;
      dir_r   <= 1'b0;
      max_r   <= MAX_RST;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      freq_r  <= freq_nxt;
      dir_r   <= dir_nxt;
      max_r   <= max_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    start_r   <= start_nxt;
    lim_r     <= lim_nxt;
    k_r       <= k_nxt;
    wsel_r    <= wsel_nxt;
    mm_r      <= mm_nxt;
    for_dir_r <= for_dir_nxt;
    neg_r     <= neg_nxt;
    any_r     <= any_nxt;
    val_r     <= val_nxt;
    fa_r      <= fa_nxt;
    da_r      <= da_nxt;
  end

  always_comb begin
    result.valid        = valid_r;
    result.frequency_hz = freq_r;
    result.freq_applied = fa_r;
    result.direction    = dir_r;
    result.dir_applied  = da_r;
  end

endmodule
